// ===== sv/strf_pkg.sv =====
// package: shared types, constants and codes of the store trace ring
`timescale 1ns / 1ps
package strf_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int MAX_BURST  = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_ADDR_LO = 2'd0;
    localparam logic [1:0] CFG_ADDR_HI = 2'd1;
    localparam logic [1:0] CFG_PC_LO   = 2'd2;
    localparam logic [1:0] CFG_PC_HI   = 2'd3;

    localparam logic [6:0]  BURST_W = 7'(MAX_BURST);
    localparam logic [63:0] DEPTH_W = 64'(RING_DEPTH);

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] store_addr;
        logic [31:0] store_value;
        logic [7:0]  store_width;
        logic [63:0] cpu_cycle;
        logic [31:0] cpu_pc;
        logic [63:0] start_seq;
        logic [63:0] to_seq;
        logic [6:0]  out_space;
        logic [6:0]  match_limit;
    } t_in_item;

    typedef struct packed {
        logic        valid_res;
        logic        last;
        logic [63:0] entry_seq;
        logic [63:0] entry_cycle;
        logic [31:0] entry_pc;
        logic [31:0] entry_addr;
        logic [31:0] entry_value;
        logic [7:0]  entry_width;
        logic [2:0]  entry_region;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_RECORD,
        CMD_QUERY,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] addr;
        logic [31:0] value;
        logic [7:0]  width;
        logic [63:0] cycle;
        logic [31:0] pc;
        logic [63:0] start_seq;
        logic [63:0] to_seq;
        logic [6:0]  limit;
    } t_cmd;

    typedef struct packed {
        logic [63:0] cycle;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] value;
        logic [7:0]  width;
    } t_ring_word;

    typedef struct packed {
        logic [31:0] addr_lo;
        logic [31:0] addr_hi;
        logic [31:0] pc_lo;
        logic [31:0] pc_hi;
    } t_filter_cfg;

    typedef enum logic [2:0] {
        B_IDLE,
        B_BOUND,
        B_LOWER,
        B_READ,
        B_CHECK,
        B_FINISH
    } t_bstate;

endpackage

// ===== sv/strf_ram.sv =====
// generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module strf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/strf_front.sv =====
// front end: accepts items, classifies them and queues commands
`timescale 1ns / 1ps
module strf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  strf_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output logic              o_cmd_valid,
    output strf_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import strf_pkg::*;

    t_cmd               r_queue [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count, n_count;

    t_cmd       cmd_new;
    logic       accept;
    logic       push;
    logic       pop;
    logic [6:0] room;
    logic [6:0] cap;

    assign o_in_stall  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        room = (i_in_item.out_space > BURST_W) ? BURST_W : i_in_item.out_space;
        cap  = (i_in_item.match_limit == '0 || i_in_item.match_limit > BURST_W)
             ? BURST_W : i_in_item.match_limit;
        cmd_new.addr      = i_in_item.store_addr;
        cmd_new.value     = i_in_item.store_value;
        cmd_new.width     = i_in_item.store_width;
        cmd_new.cycle     = i_in_item.cpu_cycle;
        cmd_new.pc        = i_in_item.cpu_pc;
        cmd_new.start_seq = i_in_item.start_seq;
        cmd_new.to_seq    = i_in_item.to_seq;
        cmd_new.limit     = (room < cap) ? room : cap;
        push              = accept;
        unique case (i_in_item.mode)
            MODE_RECORD: cmd_new.kind = CMD_RECORD;
            MODE_QUERY:  cmd_new.kind = CMD_QUERY;
            MODE_CLEAR:  cmd_new.kind = CMD_CLEAR;
            default: begin
                // unused mode is dropped
                cmd_new.kind = CMD_CLEAR;
                push         = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_new;
        end
    end

endmodule

// ===== sv/strf_back.sv =====
// back end: records stores, scans query windows, drives the result register
`timescale 1ns / 1ps
module strf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  strf_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  strf_pkg::t_filter_cfg         i_cfg,
    output logic                          o_ram_we,
    output logic [strf_pkg::RING_AW-1:0]  o_ram_waddr,
    output strf_pkg::t_ring_word          o_ram_wdata,
    output logic                          o_ram_re,
    output logic [strf_pkg::RING_AW-1:0]  o_ram_raddr,
    input  strf_pkg::t_ring_word          i_ram_rdata,
    output logic                          o_out_valid,
    output strf_pkg::t_out_item           o_out_item,
    input  logic                          i_out_stall
);
    import strf_pkg::*;

    t_bstate     r_state, n_state;
    logic [63:0] r_next_seq;
    logic [63:0] r_from, r_to, r_hi, r_floor, r_s;
    logic        r_old;
    logic [6:0]  r_limit, r_n;
    logic        r_have;
    t_out_item   r_hold;
    logic        r_out_valid;
    t_out_item   r_out;

    logic      can_push;
    logic      in_window;
    logic      pass;
    logic      take;
    logic      push_hold;
    logic      push_final;
    logic      skip;
    t_out_item cur;
    t_out_item last_item;

    assign can_push  = !r_out_valid || !i_out_stall;
    assign in_window = (r_s < r_hi) && (r_n < r_limit);
    assign pass      = (i_ram_rdata.addr >= i_cfg.addr_lo)
                    && (i_cfg.addr_hi == '0 || i_ram_rdata.addr < i_cfg.addr_hi)
                    && (i_ram_rdata.pc >= i_cfg.pc_lo)
                    && (i_cfg.pc_hi == '0 || i_ram_rdata.pc < i_cfg.pc_hi);

    always_comb begin
        cur.valid_res    = 1'b1;
        cur.last         = 1'b0;
        cur.entry_seq    = r_s;
        cur.entry_cycle  = i_ram_rdata.cycle;
        cur.entry_pc     = i_ram_rdata.pc;
        cur.entry_addr   = i_ram_rdata.addr;
        cur.entry_value  = i_ram_rdata.value;
        cur.entry_width  = i_ram_rdata.width;
        cur.entry_region = i_ram_rdata.addr[26:24];
    end

    // final transfer of a query: held entry or empty marker
    always_comb begin
        last_item      = r_have ? r_hold : '0;
        last_item.last = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == CMD_QUERY) begin
                    n_state = B_BOUND;
                end
            end
            B_BOUND: n_state = B_LOWER;
            B_LOWER: n_state = B_READ;
            B_READ:  n_state = in_window ? B_CHECK : B_FINISH;
            B_CHECK: begin
                if (!pass || !r_have || can_push) begin
                    n_state = B_READ;
                end
            end
            B_FINISH: begin
                if (can_push) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs and datapath enables
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        take       = 1'b0;
        push_hold  = 1'b0;
        push_final = 1'b0;
        skip       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                o_ram_we  = i_cmd_valid && i_cmd.kind == CMD_RECORD;
            end
            B_BOUND, B_LOWER: ;
            B_READ: o_ram_re = in_window;
            B_CHECK: begin
                skip      = !pass;
                take      = pass && (!r_have || can_push);
                push_hold = pass && r_have && can_push;
            end
            B_FINISH: push_final = can_push;
            default: ;
        endcase
    end

    assign o_ram_waddr       = r_next_seq[RING_AW-1:0];
    assign o_ram_wdata.cycle = i_cmd.cycle;
    assign o_ram_wdata.pc    = i_cmd.pc;
    assign o_ram_wdata.addr  = i_cmd.addr;
    assign o_ram_wdata.value = i_cmd.value;
    assign o_ram_wdata.width = i_cmd.width;
    assign o_ram_raddr       = r_s[RING_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_next_seq  <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && i_cmd.kind == CMD_RECORD) begin
                r_next_seq <= r_next_seq + 64'd1;
            end else if (o_cmd_pop && i_cmd.kind == CMD_CLEAR) begin
                r_next_seq <= '0;
            end
            if (take) begin
                r_have <= 1'b1;
            end else if (push_final) begin
                r_have <= 1'b0;
            end
            if (push_hold || push_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_from  <= i_cmd.start_seq;
            r_to    <= i_cmd.to_seq;
            r_limit <= i_cmd.limit;
            r_n     <= '0;
        end
        if (r_state == B_BOUND) begin
            r_hi    <= (r_to == '0 || r_to > r_next_seq) ? r_next_seq : r_to;
            r_floor <= r_next_seq - DEPTH_W;
            r_old   <= r_next_seq > DEPTH_W;
            r_s     <= r_from;
        end
        if (r_state == B_LOWER && r_old && r_s < r_floor) begin
            r_s <= r_floor;
        end
        if (take || skip) begin
            r_s <= r_s + 64'd1;
        end
        if (take) begin
            r_n    <= r_n + 7'd1;
            r_hold <= cur;
        end
        if (push_hold) begin
            r_out <= r_hold;
        end else if (push_final) begin
            r_out <= last_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/store_trace_ring_with_filter.sv =====
// top level: store trace ring with address and pc window filter
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------
//  input    | i_in_valid / o_in_stall | i_in_item
//  result   | o_out_valid / i_out_stall | o_out_item
//  config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// records and clears are done in the idle state: stores stream at one per cycle unless
// a query runs; a query has setup (bound, lower), then per scanned slot a registered
// ring read and a filter check, then a last window check and its final result
// reset clears the sequence count, the command queue and the result register; ring
// contents are not cleared
// the four-entry command queue lets the front keep accepting while the back is busy
// a stalled result holds the scan at the next matching entry until it is taken
`timescale 1ns / 1ps
module store_trace_ring_with_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  strf_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output strf_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import strf_pkg::*;

    t_filter_cfg r_cfg;

    logic               cmd_valid;
    t_cmd               cmd;
    logic               cmd_pop;
    logic               ram_we;
    logic [RING_AW-1:0] ram_waddr;
    t_ring_word         ram_wdata;
    logic               ram_re;
    logic [RING_AW-1:0] ram_raddr;
    t_ring_word         ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDR_LO: r_cfg.addr_lo <= i_cfg_data;
                CFG_ADDR_HI: r_cfg.addr_hi <= i_cfg_data;
                CFG_PC_LO:   r_cfg.pc_lo   <= i_cfg_data;
                CFG_PC_HI:   r_cfg.pc_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    strf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    strf_ram #(
        .WIDTH ($bits(t_ring_word)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    strf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (r_cfg),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ring written and read in the same cycle");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.valid_res) |-> o_out_item.last)
        else $error("empty query result without last");

    a_record_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared after a record");
`endif

endmodule
